// File: rtl/jerk_limited_velocity_tracker_defines.svh
// Assertion macros for the velocity tracker.
`ifndef JERK_LIMITED_VELOCITY_TRACKER_DEFINES_SVH
`define JERK_LIMITED_VELOCITY_TRACKER_DEFINES_SVH

`ifndef SYNTH
`define JLVT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("jlvt check failed");
`define JLVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("jlvt check failed");
`else
`define JLVT_ASSERT_IMPL(label, ante, cons)
`define JLVT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/jlvt_pkg.sv
// Shared types, constants and helpers of the velocity tracker.
package jlvt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_W      = FRAC_BITS - 1;

    localparam logic [DT_W-1:0] DT_LO = DT_W'(((2 ** FRAC_BITS) + 999) / 1000);
    localparam logic [DT_W-1:0] DT_HI = DT_W'(2 ** (FRAC_BITS - 2));

    localparam logic signed [63:0] ONE_Q   = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] TENTH_Q = (64'sd1 <<< FRAC_BITS) / 10;
    localparam logic signed [63:0] HALF_SQ = 64'sd1 <<< (2 * FRAC_BITS - 1);
    localparam logic signed [63:0] BIG31   = 64'sh7FFF_FFFF;

    localparam logic [1:0] ALU_MUL  = 2'd0;
    localparam logic [1:0] ALU_DIV  = 2'd1;
    localparam logic [1:0] ALU_SQRT = 2'd2;

    localparam logic [1:0] FN_LATCH = 2'd0;
    localparam logic [1:0] FN_STEP  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_SPEED = 3'd1;
    localparam logic [2:0] REG_ACCEL = 3'd2;
    localparam logic [2:0] REG_DECEL = 3'd3;
    localparam logic [2:0] REG_JERK  = 3'd4;
    localparam logic [2:0] REG_JON   = 3'd5;
    localparam logic [2:0] REG_ERR   = 3'd6;

    typedef struct packed {
        logic               start;
        logic [1:0]         op;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } t_alu_rsp;

    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        logic [63:0] u;
        u = x;
        return x[63] ? (64'd0 - u) : u;
    endfunction

    function automatic logic signed [63:0] trunc_q(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + (x[63] ? (ONE_Q - 64'sd1) : 64'sd0);
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [63:0] half_tz(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + (x[63] ? 64'sd1 : 64'sd0);
        return t >>> 1;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/jlvt_alu.sv
// Bit-serial multiply, divide and square root unit shared by the sequencer.
module jlvt_alu import jlvt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [63:0] r_x;
    logic [63:0] r_y;
    logic [63:0] r_z;
    logic [6:0]  r_cnt;
    logic [1:0]  r_op;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;
    logic [64:0] w_rem;
    logic        w_rem_ge;
    logic [63:0] w_sq_t;
    logic [63:0] w_res;

    always_comb begin
        w_rem    = {r_x, r_y[63]};
        w_rem_ge = (w_rem >= {1'b0, r_z});
        w_sq_t   = r_y + r_z;
        case (r_op)
            ALU_MUL: w_res = r_neg ? (64'd0 - r_x) : r_x;
            ALU_DIV: w_res = r_neg ? (64'd0 - r_y) : r_y;
            default: w_res = r_y;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                case (i_req.op)
                    ALU_MUL, ALU_DIV: begin
                        r_x   <= 64'd0;
                        r_y   <= mag64(i_req.a);
                        r_z   <= mag64(i_req.b);
                        r_cnt <= 7'd64;
                    end
                    default: begin
                        r_x   <= i_req.a;
                        r_y   <= 64'd0;
                        r_z   <= 64'h4000_0000_0000_0000;
                        r_cnt <= 7'd32;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    ALU_MUL: begin
                        if (r_z[0]) begin
                            r_x <= r_x + r_y;
                        end
                        r_y <= r_y << 1;
                        r_z <= r_z >> 1;
                    end
                    ALU_DIV: begin
                        if (w_rem_ge) begin
                            r_x <= 64'(w_rem - {1'b0, r_z});
                        end else begin
                            r_x <= w_rem[63:0];
                        end
                        r_y <= {r_y[62:0], w_rem_ge};
                    end
                    default: begin
                        if (r_x >= w_sq_t) begin
                            r_x <= r_x - w_sq_t;
                            r_y <= (r_y >> 1) + r_z;
                        end else begin
                            r_y <= r_y >> 1;
                        end
                        r_z <= r_z >> 2;
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/jerk_limited_velocity_tracker.sv
// Jerk-limited 3-D velocity command tracker, top level and sequencer.
//
//  channel  direction  handshake                      payload
//  input    in         i_in_valid / o_in_stall        i_func, i_vec_a_*, i_vec_b_*, i_time_step
//  output   out        o_out_valid / i_out_stall      o_cmd_*, o_guard_hit, o_guard_total
//  config   in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// Latch and clear items are handled while idle and do not stall the input. A step item runs
// its multiplies, divides and square roots one at a time on the shared bit-serial unit.
// Synchronous active-low reset clears the control and history state and restores the register
// defaults. The input stalls for the whole step; a finished command waits in the output register
// while the next item is taken, and a new command waits until that register is free.
`include "jerk_limited_velocity_tracker_defines.svh"

module jerk_limited_velocity_tracker import jlvt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_vec_a_x,
    input  logic signed [31:0] i_vec_a_y,
    input  logic signed [31:0] i_vec_a_z,
    input  logic signed [31:0] i_vec_b_x,
    input  logic signed [31:0] i_vec_b_y,
    input  logic signed [31:0] i_vec_b_z,
    input  logic [16:0]        i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_cmd_x,
    output logic signed [31:0] o_cmd_y,
    output logic signed [31:0] o_cmd_z,
    output logic               o_guard_hit,
    output logic [31:0]        o_guard_total,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [5:0] S_IDLE    = 6'd0;
    localparam logic [5:0] S_WAIT    = 6'd1;
    localparam logic [5:0] S_CL_HALF = 6'd2;
    localparam logic [5:0] S_CL_SQ   = 6'd3;
    localparam logic [5:0] S_CL_ACC  = 6'd4;
    localparam logic [5:0] S_CL_RT   = 6'd5;
    localparam logic [5:0] S_CL_CMP  = 6'd6;
    localparam logic [5:0] S_CL_MUL  = 6'd7;
    localparam logic [5:0] S_CL_DIV  = 6'd8;
    localparam logic [5:0] S_CL_WR   = 6'd9;
    localparam logic [5:0] S_UN_DIV  = 6'd10;
    localparam logic [5:0] S_UN_WR   = 6'd11;
    localparam logic [5:0] S_E0      = 6'd12;
    localparam logic [5:0] S_C1      = 6'd13;
    localparam logic [5:0] S_C2      = 6'd14;
    localparam logic [5:0] S_C3      = 6'd15;
    localparam logic [5:0] S_G0      = 6'd16;
    localparam logic [5:0] S_G1      = 6'd17;
    localparam logic [5:0] S_G2      = 6'd18;
    localparam logic [5:0] S_G3      = 6'd19;
    localparam logic [5:0] S_G4      = 6'd20;
    localparam logic [5:0] S_G5      = 6'd21;
    localparam logic [5:0] S_G6      = 6'd22;
    localparam logic [5:0] S_G8      = 6'd23;
    localparam logic [5:0] S_G9      = 6'd24;
    localparam logic [5:0] S_G11     = 6'd25;
    localparam logic [5:0] S_G12     = 6'd26;
    localparam logic [5:0] S_D1      = 6'd27;
    localparam logic [5:0] S_D2      = 6'd28;
    localparam logic [5:0] S_D4      = 6'd29;
    localparam logic [5:0] S_D5      = 6'd30;
    localparam logic [5:0] S_D6      = 6'd31;
    localparam logic [5:0] S_D7      = 6'd32;
    localparam logic [5:0] S_D8      = 6'd33;
    localparam logic [5:0] S_J0      = 6'd34;
    localparam logic [5:0] S_J1      = 6'd35;
    localparam logic [5:0] S_J2      = 6'd36;
    localparam logic [5:0] S_K1      = 6'd37;
    localparam logic [5:0] S_K2      = 6'd38;
    localparam logic [5:0] S_K3      = 6'd39;
    localparam logic [5:0] S_L1      = 6'd40;
    localparam logic [5:0] S_L2      = 6'd41;
    localparam logic [5:0] S_L3      = 6'd42;

    logic [5:0]         r_state;
    logic [5:0]         r_wret;
    logic [5:0]         r_cret;
    logic [1:0]         r_i;
    logic signed [63:0] r_a   [3];
    logic signed [63:0] r_b   [3];
    logic signed [63:0] r_v   [3];
    logic signed [63:0] r_cmd [3];
    logic signed [63:0] r_uc  [3];
    logic signed [63:0] r_up  [3];
    logic signed [63:0] r_acc [3];
    logic signed [63:0] r_t;
    logic signed [63:0] r_n;
    logic signed [63:0] r_nc;
    logic signed [63:0] r_ps;
    logic signed [63:0] r_cap;
    logic [DT_W-1:0]    r_dt;
    logic               r_norm_only;
    logic               r_hit;
    logic               r_slow;

    logic [30:0]        r_gain;
    logic [30:0]        r_speed_cap;
    logic [30:0]        r_accel_cap;
    logic [30:0]        r_decel_cap;
    logic [30:0]        r_jerk_cap;
    logic               r_jerk_on;
    logic [30:0]        r_err_cap;

    logic signed [31:0] r_last_cmd [3];
    logic signed [31:0] r_last_acc [3];
    logic signed [31:0] r_ref_pos  [3];
    logic signed [31:0] r_ref_vel  [3];
    logic [31:0]        r_guard;

    logic               r_out_valid;
    logic signed [31:0] r_out_cmd [3];
    logic               r_out_hit;
    logic [31:0]        r_out_total;

    t_alu_req           r_alu;
    t_alu_rsp           w_alu_rsp;

    logic signed [31:0] w_in_a [3];
    logic signed [31:0] w_in_b [3];
    logic signed [63:0] w_res;
    logic signed [63:0] w_dt64;
    logic               w_last;
    logic               w_big;

    jlvt_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_alu),
        .o_rsp   (w_alu_rsp)
    );

    assign w_in_a[0] = i_vec_a_x;
    assign w_in_a[1] = i_vec_a_y;
    assign w_in_a[2] = i_vec_a_z;
    assign w_in_b[0] = i_vec_b_x;
    assign w_in_b[1] = i_vec_b_y;
    assign w_in_b[2] = i_vec_b_z;

    assign w_res  = w_alu_rsp.res;
    assign w_dt64 = signed'(64'(r_dt));
    assign w_last = (r_i == 2'd2);
    assign w_big  = (mag64(r_v[0]) > 64'(BIG31)) || (mag64(r_v[1]) > 64'(BIG31)) ||
                    (mag64(r_v[2]) > 64'(BIG31));

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_cmd_x       = r_out_cmd[0];
    assign o_cmd_y       = r_out_cmd[1];
    assign o_cmd_z       = r_out_cmd[2];
    assign o_guard_hit   = r_out_hit;
    assign o_guard_total = r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wret      <= S_IDLE;
            r_cret      <= S_IDLE;
            r_i         <= 2'd0;
            r_norm_only <= 1'b0;
            r_hit       <= 1'b0;
            r_slow      <= 1'b0;
            r_alu       <= '0;
            r_out_valid <= 1'b0;
            r_gain      <= 31'd65536;
            r_speed_cap <= 31'd327680;
            r_accel_cap <= 31'd131072;
            r_decel_cap <= 31'd196608;
            r_jerk_cap  <= 31'd327680;
            r_jerk_on   <= 1'b1;
            r_err_cap   <= 31'd131072;
            r_guard     <= 32'd0;
            for (int k = 0; k < 3; k++) begin
                r_last_cmd[k] <= 32'sd0;
                r_last_acc[k] <= 32'sd0;
                r_ref_pos[k]  <= 32'sd0;
                r_ref_vel[k]  <= 32'sd0;
            end
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_L3)) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GAIN:  r_gain      <= i_cfg_data[30:0];
                    REG_SPEED: r_speed_cap <= i_cfg_data[30:0];
                    REG_ACCEL: r_accel_cap <= i_cfg_data[30:0];
                    REG_DECEL: r_decel_cap <= i_cfg_data[30:0];
                    REG_JERK:  r_jerk_cap  <= i_cfg_data[30:0];
                    REG_JON:   r_jerk_on   <= i_cfg_data[0];
                    REG_ERR:   r_err_cap   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        case (i_func)
                            FN_LATCH: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_ref_pos[k] <= w_in_a[k];
                                    r_ref_vel[k] <= w_in_b[k];
                                end
                            end
                            FN_CLEAR: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_last_cmd[k] <= 32'sd0;
                                    r_last_acc[k] <= 32'sd0;
                                end
                            end
                            FN_STEP: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_a[k] <= 64'(w_in_a[k]);
                                    r_b[k] <= 64'(w_in_b[k]);
                                end
                                if (i_time_step < 17'(DT_LO)) begin
                                    r_dt <= DT_LO;
                                end else if (i_time_step > 17'(DT_HI)) begin
                                    r_dt <= DT_HI;
                                end else begin
                                    r_dt <= i_time_step[DT_W-1:0];
                                end
                                r_hit   <= 1'b0;
                                r_state <= S_E0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WAIT: begin
                    r_alu.start <= 1'b0;
                    if (w_alu_rsp.done) begin
                        r_state <= r_wret;
                    end
                end

                // norm clamp of r_v against r_cap; norm only when r_norm_only
                S_CL_HALF: begin
                    if (!r_norm_only && w_big) begin
                        for (int k = 0; k < 3; k++) begin
                            r_v[k] <= half_tz(r_v[k]);
                        end
                    end else begin
                        r_t     <= 64'sd0;
                        r_i     <= 2'd0;
                        r_state <= S_CL_SQ;
                    end
                end
                S_CL_SQ: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_v[r_i], b: r_v[r_i]};
                    r_wret  <= S_CL_ACC;
                    r_state <= S_WAIT;
                end
                S_CL_ACC: begin
                    r_t <= r_t + w_res;
                    if (w_last) begin
                        r_state <= S_CL_RT;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_CL_SQ;
                    end
                end
                S_CL_RT: begin
                    r_alu   <= '{start: 1'b1, op: ALU_SQRT, a: r_t, b: 64'sd0};
                    r_wret  <= S_CL_CMP;
                    r_state <= S_WAIT;
                end
                S_CL_CMP: begin
                    r_n <= w_res;
                    r_i <= 2'd0;
                    if (!r_norm_only && (w_res > r_cap) && (w_res > 64'sd0)) begin
                        r_state <= S_CL_MUL;
                    end else begin
                        r_state <= r_cret;
                    end
                end
                S_CL_MUL: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_v[r_i], b: r_cap};
                    r_wret  <= S_CL_DIV;
                    r_state <= S_WAIT;
                end
                S_CL_DIV: begin
                    r_alu   <= '{start: 1'b1, op: ALU_DIV, a: w_res, b: r_n};
                    r_wret  <= S_CL_WR;
                    r_state <= S_WAIT;
                end
                S_CL_WR: begin
                    r_v[r_i] <= w_res;
                    if (w_last) begin
                        r_i     <= 2'd0;
                        r_state <= r_cret;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_CL_MUL;
                    end
                end

                // unit vector of r_v with norm r_n, in place
                S_UN_DIV: begin
                    r_alu   <= '{start: 1'b1, op: ALU_DIV, a: r_v[r_i] <<< FRAC_BITS, b: r_n};
                    r_wret  <= S_UN_WR;
                    r_state <= S_WAIT;
                end
                S_UN_WR: begin
                    r_v[r_i] <= w_res;
                    if (w_last) begin
                        r_i     <= 2'd0;
                        r_state <= r_cret;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_UN_DIV;
                    end
                end

                S_E0: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= 64'(r_ref_pos[k]) - r_b[k];
                    end
                    r_cap       <= signed'(64'(r_err_cap));
                    r_norm_only <= 1'b0;
                    r_cret      <= S_C1;
                    r_state     <= S_CL_HALF;
                end
                S_C1: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: signed'(64'(r_gain)), b: r_v[r_i]};
                    r_wret  <= S_C2;
                    r_state <= S_WAIT;
                end
                S_C2: begin
                    r_cmd[r_i] <= r_a[r_i] + trunc_q(w_res);
                    if (w_last) begin
                        r_state <= S_C3;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_C1;
                    end
                end
                S_C3: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= r_cmd[k];
                    end
                    r_cap   <= signed'(64'(r_speed_cap));
                    r_cret  <= S_G0;
                    r_state <= S_CL_HALF;
                end
                S_G0: begin
                    for (int k = 0; k < 3; k++) begin
                        r_cmd[k] <= r_v[k];
                        r_v[k]   <= 64'(r_ref_vel[k]);
                    end
                    r_norm_only <= 1'b1;
                    r_cret      <= S_G1;
                    r_state     <= S_CL_HALF;
                end
                S_G1: begin
                    r_nc <= r_n;
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= r_a[k];
                    end
                    r_cret  <= S_G2;
                    r_state <= S_CL_HALF;
                end
                S_G2: begin
                    if ((r_nc > TENTH_Q) && (r_n > TENTH_Q)) begin
                        for (int k = 0; k < 3; k++) begin
                            r_up[k] <= r_a[k];
                            r_v[k]  <= 64'(r_ref_vel[k]);
                        end
                        r_ps    <= r_n;
                        r_n     <= r_nc;
                        r_cret  <= S_G3;
                        r_state <= S_UN_DIV;
                    end else begin
                        r_state <= S_D1;
                    end
                end
                S_G3: begin
                    for (int k = 0; k < 3; k++) begin
                        r_uc[k] <= r_v[k];
                        r_v[k]  <= r_up[k];
                    end
                    r_n     <= r_ps;
                    r_cret  <= S_G4;
                    r_state <= S_UN_DIV;
                end
                S_G4: begin
                    for (int k = 0; k < 3; k++) begin
                        r_up[k] <= r_v[k];
                    end
                    r_t     <= 64'sd0;
                    r_state <= S_G5;
                end
                S_G5: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_uc[r_i], b: r_up[r_i]};
                    r_wret  <= S_G6;
                    r_state <= S_WAIT;
                end
                S_G6: begin
                    if (w_last) begin
                        r_i <= 2'd0;
                        if ((r_t + w_res) > HALF_SQ) begin
                            r_t     <= 64'sd0;
                            r_state <= S_G8;
                        end else begin
                            r_state <= S_D1;
                        end
                    end else begin
                        r_t     <= r_t + w_res;
                        r_i     <= r_i + 2'd1;
                        r_state <= S_G5;
                    end
                end
                S_G8: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_cmd[r_i], b: r_uc[r_i]};
                    r_wret  <= S_G9;
                    r_state <= S_WAIT;
                end
                S_G9: begin
                    if (w_last) begin
                        r_i <= 2'd0;
                        if ((r_t + w_res) < 64'sd0) begin
                            r_n     <= trunc_q(r_t + w_res);
                            r_state <= S_G11;
                        end else begin
                            r_state <= S_D1;
                        end
                    end else begin
                        r_t     <= r_t + w_res;
                        r_i     <= r_i + 2'd1;
                        r_state <= S_G8;
                    end
                end
                S_G11: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_n, b: r_uc[r_i]};
                    r_wret  <= S_G12;
                    r_state <= S_WAIT;
                end
                S_G12: begin
                    r_cmd[r_i] <= r_cmd[r_i] - trunc_q(w_res);
                    if (w_last) begin
                        r_i     <= 2'd0;
                        r_guard <= r_guard + 32'd1;
                        r_hit   <= 1'b1;
                        r_state <= S_D1;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_G11;
                    end
                end

                // desired acceleration
                S_D1: begin
                    r_alu   <= '{start: 1'b1, op: ALU_DIV,
                                 a: (r_cmd[r_i] - 64'(r_last_cmd[r_i])) <<< FRAC_BITS,
                                 b: w_dt64};
                    r_wret  <= S_D2;
                    r_state <= S_WAIT;
                end
                S_D2: begin
                    r_acc[r_i] <= w_res;
                    if (w_last) begin
                        for (int k = 0; k < 3; k++) begin
                            r_v[k] <= 64'(r_last_cmd[k]);
                        end
                        r_i         <= 2'd0;
                        r_norm_only <= 1'b1;
                        r_cret      <= S_D4;
                        r_state     <= S_CL_HALF;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_D1;
                    end
                end
                S_D4: begin
                    r_ps   <= r_n;
                    r_slow <= 1'b0;
                    if (r_n > 64'sd0) begin
                        r_cret  <= S_D5;
                        r_state <= S_UN_DIV;
                    end else begin
                        r_state <= S_D8;
                    end
                end
                S_D5: begin
                    for (int k = 0; k < 3; k++) begin
                        r_up[k] <= r_v[k];
                    end
                    r_t     <= 64'sd0;
                    r_state <= S_D6;
                end
                S_D6: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_cmd[r_i], b: r_up[r_i]};
                    r_wret  <= S_D7;
                    r_state <= S_WAIT;
                end
                S_D7: begin
                    if (w_last) begin
                        r_i     <= 2'd0;
                        r_slow  <= ((r_t + w_res) < (r_ps <<< FRAC_BITS));
                        r_state <= S_D8;
                    end else begin
                        r_t     <= r_t + w_res;
                        r_i     <= r_i + 2'd1;
                        r_state <= S_D6;
                    end
                end
                S_D8: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= r_acc[k];
                    end
                    r_cap       <= r_slow ? signed'(64'(r_decel_cap)) :
                                            signed'(64'(r_accel_cap));
                    r_norm_only <= 1'b0;
                    r_cret      <= S_J0;
                    r_state     <= S_CL_HALF;
                end

                // jerk limit
                S_J0: begin
                    if (r_jerk_on) begin
                        for (int k = 0; k < 3; k++) begin
                            r_v[k] <= r_v[k] - 64'(r_last_acc[k]);
                        end
                        r_alu   <= '{start: 1'b1, op: ALU_MUL,
                                     a: signed'(64'(r_jerk_cap)), b: w_dt64};
                        r_wret  <= S_J1;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_K1;
                    end
                end
                S_J1: begin
                    r_cap   <= w_res >>> FRAC_BITS;
                    r_cret  <= S_J2;
                    r_state <= S_CL_HALF;
                end
                S_J2: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= r_v[k] + 64'(r_last_acc[k]);
                    end
                    r_state <= S_K1;
                end

                // integrate and clamp the speed again, then store the acceleration and issue the command
                S_K1: begin
                    r_alu   <= '{start: 1'b1, op: ALU_MUL, a: r_v[r_i], b: w_dt64};
                    r_wret  <= S_K2;
                    r_state <= S_WAIT;
                end
                S_K2: begin
                    r_cmd[r_i] <= 64'(r_last_cmd[r_i]) + trunc_q(w_res);
                    if (w_last) begin
                        r_state <= S_K3;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_K1;
                    end
                end
                S_K3: begin
                    for (int k = 0; k < 3; k++) begin
                        r_v[k] <= r_cmd[k];
                    end
                    r_i     <= 2'd0;
                    r_cap   <= signed'(64'(r_speed_cap));
                    r_cret  <= S_L1;
                    r_state <= S_CL_HALF;
                end
                S_L1: begin
                    r_alu   <= '{start: 1'b1, op: ALU_DIV,
                                 a: (r_v[r_i] - 64'(r_last_cmd[r_i])) <<< FRAC_BITS,
                                 b: w_dt64};
                    r_wret  <= S_L2;
                    r_state <= S_WAIT;
                end
                S_L2: begin
                    r_last_acc[r_i] <= sat32(w_res);
                    if (w_last) begin
                        r_i     <= 2'd0;
                        r_state <= S_L3;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_L1;
                    end
                end
                S_L3: begin
                    if (!r_out_valid || !i_out_stall) begin
                        for (int k = 0; k < 3; k++) begin
                            r_last_cmd[k] <= sat32(r_v[k]);
                            r_out_cmd[k]  <= sat32(r_v[k]);
                        end
                        r_out_hit   <= r_hit;
                        r_out_total <= r_guard;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `JLVT_ASSERT_IMPL(a_done_in_wait, w_alu_rsp.done, r_state == S_WAIT)
    `JLVT_ASSERT_IMPL(a_start_to_wait, r_alu.start, r_state == S_WAIT)
    `JLVT_ASSERT_NEXT(a_full_holds, (r_state == S_L3) && r_out_valid && i_out_stall, r_state == S_L3)
    `JLVT_ASSERT_NEXT(a_step_result, (r_state == S_L3) && (!r_out_valid || !i_out_stall), o_out_valid && (r_state == S_IDLE))

endmodule

// File: verif/tb.sv
// Testbench for the jerk-limited velocity tracker: directed table, random traffic, self-check.
`timescale 1ns / 100ps

module tb;
    import jlvt_pkg::*;

    localparam logic [1:0] FN_IGNORED = 2'd3;
    localparam int         LIMIT      = 60_000_000;
    localparam int         SETTLE     = 4000;
    localparam int         N_PHASES   = 8;
    localparam int         PER_PHASE  = 140;

    typedef longint t_vec [3];

    typedef struct {
        logic signed [31:0] cmd [3];
        logic               hit;
        logic [31:0]        total;
    } t_cmd;

    typedef struct {
        logic [1:0]         func;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic [16:0]        dt;
        bit                 typed;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = '0;
    logic signed [31:0] i_vec_a_x = '0, i_vec_a_y = '0, i_vec_a_z = '0;
    logic signed [31:0] i_vec_b_x = '0, i_vec_b_y = '0, i_vec_b_z = '0;
    logic [16:0]        i_time_step = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_cmd_x, o_cmd_y, o_cmd_z;
    logic               o_guard_hit;
    logic [31:0]        o_guard_total;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    jerk_limited_velocity_tracker DUT (.*);

    always #5 i_clk = ~i_clk;

    // tracker model state
    longint unsigned    gain, spd_cap, acc_cap, dec_cap, jrk_cap, err_cap;
    bit                 jerk_on;
    logic signed [31:0] prev_cmd [3], prev_acc [3], ref_pos [3], ref_vel [3];
    logic [31:0]        guard_cnt;

    t_cmd    pending_cmds [$];
    int      n_errors = 0;
    int      cycles = 0;
    bit      want_hold = 1'b0;

    function automatic longint unsigned umag(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint norm3(t_vec v);
        longint unsigned s;
        s = 0;
        for (int i = 0; i < 3; i++) s += umag(v[i]) * umag(v[i]);
        return longint'(isqrt(s));
    endfunction

    function automatic void clamp_vec(inout t_vec v, input longint cap);
        longint n;
        while (umag(v[0]) > BIG31 || umag(v[1]) > BIG31 || umag(v[2]) > BIG31)
            for (int i = 0; i < 3; i++) v[i] = v[i] / 2;
        n = norm3(v);
        if (n > cap && n > 0)
            for (int i = 0; i < 3; i++) v[i] = v[i] * cap / n;
    endfunction

    function automatic void unit3(t_vec v, longint n, output t_vec u);
        for (int i = 0; i < 3; i++) u[i] = v[i] * ONE_Q / n;
    endfunction

    function automatic longint dot(t_vec a, t_vec b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic void reset_model();
        gain = 65536; spd_cap = 327680; acc_cap = 131072; dec_cap = 196608;
        jrk_cap = 327680; jerk_on = 1'b1; err_cap = 131072;
        for (int i = 0; i < 3; i++) begin
            prev_cmd[i] = 0; prev_acc[i] = 0; ref_pos[i] = 0; ref_vel[i] = 0;
        end
        guard_cnt = 0;
    endfunction

    // advance the model by one item; returns 1 when a command is produced
    function automatic bit track(t_row r, output t_cmd res);
        t_vec   a, b, err, cmd, prev, la, des, acc, hv, uc, up;
        longint dt, nc, np, ps, raw, lon;
        bit     slow;
        slow = 1'b0;
        res.hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = r.a[i];
            b[i] = r.b[i];
        end
        case (r.func)
            FN_LATCH: begin
                for (int i = 0; i < 3; i++) begin
                    ref_pos[i] = r.a[i];
                    ref_vel[i] = r.b[i];
                end
                return 1'b0;
            end
            FN_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                    prev_cmd[i] = 0;
                    prev_acc[i] = 0;
                end
                return 1'b0;
            end
            FN_STEP: ;
            default: return 1'b0;
        endcase
        dt = r.dt;
        if (dt < DT_LO) dt = DT_LO;
        if (dt > DT_HI) dt = DT_HI;
        for (int i = 0; i < 3; i++) begin
            err[i] = longint'(ref_pos[i]) - b[i];
            prev[i] = prev_cmd[i];
            la[i] = prev_acc[i];
            hv[i] = ref_vel[i];
        end
        clamp_vec(err, err_cap);
        for (int i = 0; i < 3; i++) cmd[i] = a[i] + longint'(gain) * err[i] / ONE_Q;
        clamp_vec(cmd, spd_cap);
        nc = norm3(hv);
        np = norm3(a);
        if (nc > TENTH_Q && np > TENTH_Q) begin
            unit3(hv, nc, uc);
            unit3(a, np, up);
            if (dot(uc, up) > ONE_Q * ONE_Q / 2) begin
                raw = dot(cmd, uc);
                if (raw < 0) begin
                    lon = raw / ONE_Q;
                    for (int i = 0; i < 3; i++) cmd[i] -= lon * uc[i] / ONE_Q;
                    guard_cnt = guard_cnt + 1;
                    res.hit = 1'b1;
                end
            end
        end
        for (int i = 0; i < 3; i++) des[i] = (cmd[i] - prev[i]) * ONE_Q / dt;
        ps = norm3(prev);
        if (ps > 0) begin
            unit3(prev, ps, up);
            if (dot(cmd, up) < ps * ONE_Q) slow = 1'b1;
        end
        clamp_vec(des, slow ? dec_cap : acc_cap);
        if (jerk_on) begin
            for (int i = 0; i < 3; i++) acc[i] = des[i] - la[i];
            clamp_vec(acc, longint'(jrk_cap) * dt / ONE_Q);
            for (int i = 0; i < 3; i++) acc[i] += la[i];
        end else begin
            acc = des;
        end
        for (int i = 0; i < 3; i++) cmd[i] = prev[i] + acc[i] * dt / ONE_Q;
        clamp_vec(cmd, spd_cap);
        for (int i = 0; i < 3; i++) begin
            prev_acc[i] = clip32((cmd[i] - prev[i]) * ONE_Q / dt);
            prev_cmd[i] = clip32(cmd[i]);
            res.cmd[i] = prev_cmd[i];
        end
        res.total = guard_cnt;
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_cmd e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected command transfer");
                n_errors++;
            end else begin
                e = pending_cmds.pop_front();
                if (o_cmd_x !== e.cmd[0]) begin
                    $error("cmd_x exp %0d got %0d", e.cmd[0], o_cmd_x); n_errors++;
                end
                if (o_cmd_y !== e.cmd[1]) begin
                    $error("cmd_y exp %0d got %0d", e.cmd[1], o_cmd_y); n_errors++;
                end
                if (o_cmd_z !== e.cmd[2]) begin
                    $error("cmd_z exp %0d got %0d", e.cmd[2], o_cmd_z); n_errors++;
                end
                if (o_guard_hit !== e.hit) begin
                    $error("guard_hit exp %0d got %0d", e.hit, o_guard_hit); n_errors++;
                end
                if (o_guard_total !== e.total) begin
                    $error("guard_total exp %0d got %0d", e.total, o_guard_total); n_errors++;
                end
            end
        end
    end

    // receiver back-pressure
    initial begin
        int len, pick;
        @(posedge i_rst_n);
        forever begin
            if (want_hold) begin
                i_out_stall <= 1'b1;
                repeat (30000) @(posedge i_clk);
                want_hold = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                i_out_stall <= 1'b0;
                len = $urandom_range(1, 400);
            end else if (pick < 95) begin
                i_out_stall <= 1'b1;
                len = $urandom_range(1, 6);
            end else begin
                i_out_stall <= 1'b1;
                len = $urandom_range(50, 3000);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    task automatic sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return;
        i_in_valid <= 1'b0;
        if (pick < 92) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        else repeat ($urandom_range(20, 2000)) @(posedge i_clk);
    endtask

    task automatic send(t_row r, t_cmd typed_cmd);
        t_cmd res;
        i_in_valid  <= 1'b1;
        i_func      <= r.func;
        i_vec_a_x   <= r.a[0]; i_vec_a_y <= r.a[1]; i_vec_a_z <= r.a[2];
        i_vec_b_x   <= r.b[0]; i_vec_b_y <= r.b[1]; i_vec_b_z <= r.b[2];
        i_time_step <= r.dt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (track(r, res)) pending_cmds.push_back(r.typed ? typed_cmd : res);
        sender_gap();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // hold valid between back-to-back writes; the caller drops it after the last one
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GAIN:  gain    = val[30:0];
            REG_SPEED: spd_cap = val[30:0];
            REG_ACCEL: acc_cap = val[30:0];
            REG_DECEL: dec_cap = val[30:0];
            REG_JERK:  jrk_cap = val[30:0];
            REG_JON:   jerk_on = val[0];
            REG_ERR:   err_cap = val[30:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] cap_value(int mode, logic [31:0] lo);
        case (mode)
            0: return lo;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(32'h4000, 32'h8_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic configure(int ph);
        int mode;
        mode = (ph == 1) ? 1 : (ph == 2) ? 0 : -1;
        write_reg(REG_GAIN,  cap_value(mode < 0 ? $urandom_range(0, 3) : mode, 32'd0));
        write_reg(REG_SPEED, cap_value(mode < 0 ? $urandom_range(0, 3) : mode, 32'd1));
        write_reg(REG_ACCEL, cap_value(mode < 0 ? $urandom_range(0, 3) : mode, 32'd1));
        write_reg(REG_DECEL, cap_value(mode < 0 ? $urandom_range(0, 3) : mode, 32'd1));
        write_reg(REG_JERK,  cap_value(mode < 0 ? $urandom_range(0, 3) : mode, 32'd1));
        write_reg(REG_JON,   mode == 1 ? 32'd1 : mode == 0 ? 32'd0 : $urandom);
        write_reg(REG_ERR,   cap_value(mode < 0 ? $urandom_range(0, 3) : mode, 32'd1));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] near_val();
        return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endfunction

    function automatic t_row random_row(bit noise, logic signed [31:0] base [3]);
        t_row r;
        int   pick;
        pick = $urandom_range(0, 99);
        r.func = noise ? 2'($urandom) : pick < 20 ? FN_LATCH : pick < 27 ? FN_CLEAR : FN_STEP;
        r.typed = 1'b0;
        for (int i = 0; i < 3; i++) begin
            r.a[i] = noise ? $urandom : base[i] + near_val() / 4;
            r.b[i] = noise ? $urandom : near_val();
        end
        r.dt = noise ? 17'($urandom_range(0, 65536)) : 17'($urandom_range(66, 16384));
        return r;
    endfunction

    initial begin
        t_row                dir_rows [$];
        t_row                r;
        t_cmd                zero_cmd, none;
        logic signed [31:0]  heading [3];
        int                  sent;
        logic signed [31:0]  mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        zero_cmd.cmd = '{0, 0, 0}; zero_cmd.hit = 1'b0; zero_cmd.total = 0;
        none = zero_cmd;
        reset_model();

        dir_rows.push_back('{FN_STEP,  '{0, 0, 0}, '{0, 0, 0}, 17'd0, 1'b1});
        dir_rows.push_back('{FN_LATCH, '{mx, mx, mx}, '{mn, mn, mn}, 17'd0, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{mx, mx, mx}, '{mn, mn, mn}, 17'd0, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{mn, mn, mn}, '{mx, mx, mx}, 17'd65536, 1'b0});
        dir_rows.push_back('{FN_LATCH, '{mn, mn, mn}, '{mx, mx, mx}, 17'h1FFFF, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{mn, mx, 0}, '{mx, 0, mn}, 17'd65, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{0, 0, 0}, '{0, 0, 0}, 17'd66, 1'b0});
        dir_rows.push_back('{FN_IGNORED, '{-1, -1, -1}, '{-1, -1, -1}, 17'h1FFFF, 1'b0});
        dir_rows.push_back('{FN_CLEAR, '{0, 0, 0}, '{0, 0, 0}, 17'd0, 1'b0});
        dir_rows.push_back('{FN_LATCH, '{0, 0, 0}, '{65536, 0, 0}, 17'd0, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{65536, 0, 0}, '{655360, 0, 0}, 17'd6554, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{65536, 1000, 0}, '{655360, 0, 0}, 17'd16384, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{65536, 1000, 0}, '{655360, 0, 0}, 17'd16385, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{-65536, 0, 0}, '{655360, 0, 0}, 17'd6554, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{6553, 0, 0}, '{655360, 0, 0}, 17'd6554, 1'b0});
        dir_rows.push_back('{FN_LATCH, '{1, 2, 3}, '{0, 0, 6554}, 17'd0, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{0, 0, 6554}, '{0, 0, 0}, 17'd16383, 1'b0});
        dir_rows.push_back('{FN_CLEAR, '{0, 0, 0}, '{0, 0, 0}, 17'd0, 1'b0});
        dir_rows.push_back('{FN_STEP,  '{0, 0, 65536}, '{1, 2, 3}, 17'd1000, 1'b0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) send(dir_rows[k], zero_cmd);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            configure(ph);
            if (ph == 3) want_hold = 1'b1;
            sent = 0;
            while (sent < PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    r = random_row(1'b1, heading);
                    send(r, none);
                    if (r.func != FN_IGNORED) sent++;
                end else begin
                    for (int i = 0; i < 3; i++) heading[i] = near_val();
                    r = random_row(1'b0, heading);
                    r.func = FN_LATCH;
                    r.b = heading;
                    send(r, none);
                    sent++;
                    repeat ($urandom_range(2, 8)) begin
                        r = random_row(1'b0, heading);
                        if ($urandom_range(0, 3) != 0) r.func = FN_STEP;
                        send(r, none);
                        sent++;
                    end
                end
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/jlvt_pkg.sv
rtl/jlvt_alu.sv
rtl/jerk_limited_velocity_tracker.sv
verif/tb.sv
